### src/fcsg_pkg.sv
// Package for the five-channel sound generator: command codes, register
// offsets and the constant lookup tables. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package fcsg_pkg;

  localparam logic [1:0] CMD_TICK    = 2'd0;
  localparam logic [1:0] CMD_WRITE   = 2'd1;
  localparam logic [1:0] CMD_DELIVER = 2'd2;

  localparam logic [4:0] REG_P1_CTRL   = 5'h00;
  localparam logic [4:0] REG_P1_SWEEP  = 5'h01;
  localparam logic [4:0] REG_P1_LO     = 5'h02;
  localparam logic [4:0] REG_P1_HI     = 5'h03;
  localparam logic [4:0] REG_P2_CTRL   = 5'h04;
  localparam logic [4:0] REG_P2_SWEEP  = 5'h05;
  localparam logic [4:0] REG_P2_LO     = 5'h06;
  localparam logic [4:0] REG_P2_HI     = 5'h07;
  localparam logic [4:0] REG_TRI_LIN   = 5'h08;
  localparam logic [4:0] REG_TRI_LO    = 5'h0A;
  localparam logic [4:0] REG_TRI_HI    = 5'h0B;
  localparam logic [4:0] REG_NOI_CTRL  = 5'h0C;
  localparam logic [4:0] REG_NOI_PER   = 5'h0E;
  localparam logic [4:0] REG_NOI_LEN   = 5'h0F;
  localparam logic [4:0] REG_DMC_CTRL  = 5'h10;
  localparam logic [4:0] REG_DMC_LEVEL = 5'h11;
  localparam logic [4:0] REG_DMC_ADDR  = 5'h12;
  localparam logic [4:0] REG_DMC_LEN   = 5'h13;
  localparam logic [4:0] REG_STATUS    = 5'h15;
  localparam logic [4:0] REG_FRAME     = 5'h17;

  localparam logic [10:0] SWEEP_MAX = 11'h7FF;

  typedef struct packed {
    logic [3:0] divider;
    logic [3:0] decay;
    logic       start;
  } env_t;

  function automatic logic [7:0] duty_mask(input logic [1:0] d);
    unique case (d)
      2'd0: duty_mask = 8'h80;
      2'd1: duty_mask = 8'hC0;
      2'd2: duty_mask = 8'hF0;
      default: duty_mask = 8'h3F;
    endcase
  endfunction

  function automatic logic [7:0] length_lookup(input logic [4:0] i);
    logic [7:0] t [32];
    t = '{8'd10, 8'd254, 8'd20, 8'd2, 8'd40, 8'd4, 8'd80, 8'd6,
          8'd160, 8'd8, 8'd60, 8'd10, 8'd14, 8'd12, 8'd26, 8'd14,
          8'd12, 8'd16, 8'd24, 8'd18, 8'd48, 8'd20, 8'd96, 8'd22,
          8'd192, 8'd24, 8'd72, 8'd26, 8'd16, 8'd28, 8'd32, 8'd30};
    length_lookup = t[i];
  endfunction

  function automatic logic [10:0] noise_period(input logic [3:0] i);
    logic [10:0] t [16];
    t = '{11'd1, 11'd3, 11'd7, 11'd15, 11'd31, 11'd47, 11'd63, 11'd79,
          11'd100, 11'd126, 11'd189, 11'd253, 11'd380, 11'd507, 11'd1016, 11'd2033};
    noise_period = t[i];
  endfunction

  function automatic logic [7:0] delta_rate(input logic [3:0] i);
    logic [7:0] t [16];
    t = '{8'd213, 8'd189, 8'd169, 8'd159, 8'd142, 8'd126, 8'd112, 8'd106,
          8'd94, 8'd79, 8'd70, 8'd63, 8'd52, 8'd41, 8'd35, 8'd26};
    delta_rate = t[i];
  endfunction

  function automatic logic [14:0] frame_point(input logic [2:0] i);
    unique case (i)
      3'd0: frame_point = 15'd3728;
      3'd1: frame_point = 15'd7456;
      3'd2: frame_point = 15'd11185;
      3'd3: frame_point = 15'd14914;
      default: frame_point = 15'd18640;
    endcase
  endfunction

  // Clock one envelope unit on a quarter frame.
  function automatic env_t env_clock(input env_t e, input logic [3:0] vol,
                                     input logic loop_en);
    env_t r;
    r = e;
    if (e.start) begin
      r.start = 1'b0;
      r.decay = 4'd15;
      r.divider = vol;
    end else if (e.divider == 4'd0) begin
      r.divider = vol;
      if (e.decay != 4'd0) r.decay = e.decay - 4'd1;
      else if (loop_en) r.decay = 4'd15;
    end else begin
      r.divider = e.divider - 4'd1;
    end
    return r;
  endfunction

endpackage
`default_nettype wire

### src/five_channel_sound_generator.sv
// Five-channel sound generator. The result of an accepted item is offered in
// the next cycle. Throughput: one item per cycle; the output register is
// loaded whenever it is empty or being taken, so a stalled consumer holds in.
// Reset (rst_n low, synchronous) returns all channel state to power-up values.
// Depends on fcsg_pkg and fcsg_pulse.
`timescale 1ns / 1ps
`default_nettype none
module five_channel_sound_generator import fcsg_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  in_command,
  input  wire logic [4:0]  in_reg_offset,
  input  wire logic [7:0]  in_data,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic      [3:0]  out_pulse_one_level,
  output logic      [3:0]  out_pulse_two_level,
  output logic      [3:0]  out_triangle_level,
  output logic      [3:0]  out_noise_level,
  output logic      [6:0]  out_delta_level,
  output logic             out_fetch_request,
  output logic      [15:0] out_fetch_address
);

  logic acc, tick, wr, dlv, apu_clk, quarter, half;
  logic out_valid_r;
  assign in_ready = !out_valid_r || out_ready;
  assign acc  = in_valid && in_ready;
  assign tick = acc && in_command == CMD_TICK;
  assign wr   = acc && in_command == CMD_WRITE;
  assign dlv  = acc && in_command == CMD_DELIVER;

  function automatic logic wsel(input logic w, input logic [4:0] o, input logic [4:0] r);
    return w && o == r;
  endfunction

  logic [4:0] en_r;
  logic       toggle_r;
  logic       wr_status, wr_frame;
  assign wr_status = wsel(wr, in_reg_offset, REG_STATUS);
  assign wr_frame  = wsel(wr, in_reg_offset, REG_FRAME);
  assign apu_clk = tick && toggle_r;

  // frame sequencer
  logic [14:0] fdiv_r;
  logic [2:0]  fstep_r, cur_step;
  logic        five_r, fhit;
  always_comb begin
    cur_step = (fstep_r >= (five_r ? 3'd5 : 3'd4)) ? 3'd0 : fstep_r;
    fhit = tick && !toggle_r && fdiv_r == frame_point(cur_step);
    quarter = (fhit && (five_r ? cur_step != 3'd3 : cur_step != 3'd4))
              || (wr_frame && in_data[7]);
    half = (fhit && (cur_step == 3'd1 || (five_r ? cur_step == 3'd4 : cur_step == 3'd3)))
           || (wr_frame && in_data[7]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fdiv_r <= '0; fstep_r <= '0; five_r <= 1'b0; toggle_r <= 1'b0; en_r <= '0;
    end else begin
      if (tick) begin
        toggle_r <= !toggle_r;
        if (toggle_r) fdiv_r <= fdiv_r + 15'd1;
        else if (fhit) begin
          if (cur_step + 3'd1 == (five_r ? 3'd5 : 3'd4)) begin
            fstep_r <= '0;
            fdiv_r <= 15'h7FFF;
          end else begin
            fstep_r <= cur_step + 3'd1;
          end
        end else begin
          fstep_r <= cur_step;
        end
      end
      if (wr_frame) begin
        five_r <= in_data[7]; fdiv_r <= '0; fstep_r <= '0;
      end
      if (wr_status) en_r <= in_data[4:0];
    end
  end

  logic [3:0] p1_lvl, p2_lvl;
  fcsg_pulse #(.CH_ONE(1'b1)) u_p1 (
    .clk, .rst_n, .apu_clk, .quarter, .half,
    .wr_ctrl(wsel(wr, in_reg_offset, REG_P1_CTRL)),
    .wr_sweep(wsel(wr, in_reg_offset, REG_P1_SWEEP)),
    .wr_lo(wsel(wr, in_reg_offset, REG_P1_LO)),
    .wr_hi(wsel(wr, in_reg_offset, REG_P1_HI)),
    .wr_status, .enable(wr_status ? in_data[0] : en_r[0]), .data(in_data), .level(p1_lvl));
  fcsg_pulse #(.CH_ONE(1'b0)) u_p2 (
    .clk, .rst_n, .apu_clk, .quarter, .half,
    .wr_ctrl(wsel(wr, in_reg_offset, REG_P2_CTRL)),
    .wr_sweep(wsel(wr, in_reg_offset, REG_P2_SWEEP)),
    .wr_lo(wsel(wr, in_reg_offset, REG_P2_LO)),
    .wr_hi(wsel(wr, in_reg_offset, REG_P2_HI)),
    .wr_status, .enable(wr_status ? in_data[1] : en_r[1]), .data(in_data), .level(p2_lvl));

  // triangle
  logic        tctl_r, lin_reload_r;
  logic [6:0]  treload_r;
  logic [10:0] tper_r, tcnt_r;
  logic [4:0]  tstep_r;
  logic [7:0]  lin_r, tlen_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tctl_r <= 1'b0; lin_reload_r <= 1'b0; treload_r <= '0; tper_r <= '0;
      tcnt_r <= '0; tstep_r <= '0; lin_r <= '0; tlen_r <= '0;
    end else begin
      if (tick) begin
        if (tcnt_r == 11'd0) begin
          tcnt_r <= tper_r;
          if (lin_r != 8'd0 && tlen_r != 8'd0) tstep_r <= tstep_r + 5'd1;
        end else begin
          tcnt_r <= tcnt_r - 11'd1;
        end
      end
      if (quarter) begin
        if (lin_reload_r) lin_r <= {1'b0, treload_r};
        else if (lin_r != 8'd0) lin_r <= lin_r - 8'd1;
        if (!tctl_r) lin_reload_r <= 1'b0;
      end
      if (half && tlen_r != 8'd0 && !tctl_r) tlen_r <= tlen_r - 8'd1;
      if (wsel(wr, in_reg_offset, REG_TRI_LIN)) begin
        tctl_r <= in_data[7]; treload_r <= in_data[6:0];
      end
      if (wsel(wr, in_reg_offset, REG_TRI_LO)) tper_r <= {tper_r[10:8], in_data};
      if (wsel(wr, in_reg_offset, REG_TRI_HI)) begin
        if (en_r[2]) tlen_r <= length_lookup(in_data[7:3]);
        tper_r <= {in_data[2:0], tper_r[7:0]};
        lin_reload_r <= 1'b1;
      end
      if (wr_status && !in_data[2]) tlen_r <= '0;
    end
  end

  // noise
  logic [14:0] lfsr_r;
  logic        nhalt_r, nconst_r, nmode_r;
  logic [3:0]  nvol_r, nidx_r;
  logic [10:0] ncnt_r;
  logic [7:0]  nlen_r;
  env_t        nenv_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lfsr_r <= 15'd1; nhalt_r <= 1'b0; nconst_r <= 1'b0; nmode_r <= 1'b0;
      nvol_r <= '0; nidx_r <= '0; ncnt_r <= '0; nlen_r <= '0; nenv_r <= '0;
    end else begin
      if (apu_clk) begin
        if (ncnt_r == 11'd0) begin
          ncnt_r <= noise_period(nidx_r);
          lfsr_r <= {lfsr_r[0] ^ (nmode_r ? lfsr_r[6] : lfsr_r[1]), lfsr_r[14:1]};
        end else begin
          ncnt_r <= ncnt_r - 11'd1;
        end
      end
      if (quarter) nenv_r <= env_clock(nenv_r, nvol_r, nhalt_r);
      if (half && nlen_r != 8'd0 && !nhalt_r) nlen_r <= nlen_r - 8'd1;
      if (wsel(wr, in_reg_offset, REG_NOI_CTRL)) begin
        nhalt_r <= in_data[5]; nconst_r <= in_data[4]; nvol_r <= in_data[3:0];
      end
      if (wsel(wr, in_reg_offset, REG_NOI_PER)) begin
        nmode_r <= in_data[7]; nidx_r <= in_data[3:0];
      end
      if (wsel(wr, in_reg_offset, REG_NOI_LEN)) begin
        if (en_r[3]) nlen_r <= length_lookup(in_data[7:3]);
        nenv_r.start <= 1'b1;
      end
      if (wr_status && !in_data[3]) nlen_r <= '0;
    end
  end

  // delta channel
  logic        dloop_r, dempty_r, dsilent_r;
  logic [3:0]  drate_r;
  logic [15:0] dstart_r, daddr_r;
  logic [11:0] dlen_r, drem_r;
  logic [7:0]  dtimer_r, dshift_r, dbuf_r;
  logic [2:0]  dbits_r;
  logic [6:0]  dlevel_r;
  logic        want;
  assign want = dempty_r && drem_r != 12'd0;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dloop_r <= 1'b0; dempty_r <= 1'b1; dsilent_r <= 1'b1; drate_r <= '0;
      dstart_r <= '0; daddr_r <= '0; dlen_r <= '0; drem_r <= '0; dtimer_r <= '0;
      dshift_r <= '0; dbuf_r <= '0; dbits_r <= '0; dlevel_r <= '0;
    end else begin
      if (apu_clk) begin
        if (dtimer_r == 8'd0) begin
          dtimer_r <= delta_rate(drate_r);
          if (!dsilent_r) begin
            if (dshift_r[0]) begin
              if (dlevel_r <= 7'd125) dlevel_r <= dlevel_r + 7'd2;
            end else if (dlevel_r >= 7'd2) begin
              dlevel_r <= dlevel_r - 7'd2;
            end
          end
          dbits_r <= dbits_r - 3'd1;
          // at the end of a byte, load the buffer or go silent
          if (dbits_r == 3'd1 && !dempty_r) begin
            dsilent_r <= 1'b0; dshift_r <= dbuf_r; dempty_r <= 1'b1;
          end else begin
            dshift_r <= dshift_r >> 1;
            if (dbits_r == 3'd1) dsilent_r <= 1'b1;
          end
        end else begin
          dtimer_r <= dtimer_r - 8'd1;
        end
      end
      if (dlv && want) begin
        dbuf_r <= in_data;
        dempty_r <= 1'b0;
        if (drem_r == 12'd1 && dloop_r) begin
          daddr_r <= dstart_r; drem_r <= dlen_r;
        end else begin
          daddr_r <= (daddr_r == 16'hFFFF) ? 16'h8000 : daddr_r + 16'd1;
          drem_r <= drem_r - 12'd1;
        end
      end
      if (wsel(wr, in_reg_offset, REG_DMC_CTRL)) begin
        dloop_r <= in_data[6]; drate_r <= in_data[3:0];
      end
      if (wsel(wr, in_reg_offset, REG_DMC_LEVEL)) dlevel_r <= in_data[6:0];
      if (wsel(wr, in_reg_offset, REG_DMC_ADDR)) dstart_r <= {2'b11, in_data, 6'd0};
      if (wsel(wr, in_reg_offset, REG_DMC_LEN)) dlen_r <= {in_data, 4'd0} + 12'd1;
      if (wr_status) begin
        if (!in_data[4]) drem_r <= '0;
        else if (drem_r == 12'd0) begin
          daddr_r <= dstart_r; drem_r <= dlen_r;
        end
      end
    end
  end

  // result valid; channel state only moves on an accepted item, so the levels
  // below hold the result of the last item until it is taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_ready) begin
      out_valid_r <= acc;
    end
  end
  assign out_valid = out_valid_r;

  always_comb begin
    out_pulse_one_level = p1_lvl;
    out_pulse_two_level = p2_lvl;
    out_triangle_level  = tstep_r[4] ? ~tstep_r[3:0] : tstep_r[3:0];
    out_noise_level     = (!lfsr_r[0] && nlen_r != 8'd0) ?
                          (nconst_r ? nvol_r : nenv_r.decay) : 4'd0;
    out_delta_level     = dlevel_r;
    out_fetch_request   = want;
    out_fetch_address   = want ? daddr_r : 16'd0;
  end

endmodule
`default_nettype wire

### src/fcsg_pulse.sv
// One pulse channel: settings, timer, sweep, envelope and length counter.
// Depends on fcsg_pkg.
`timescale 1ns / 1ps
`default_nettype none
module fcsg_pulse import fcsg_pkg::*; #(
  parameter bit CH_ONE = 1'b1
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       apu_clk,
  input  wire logic       quarter,
  input  wire logic       half,
  input  wire logic       wr_ctrl,
  input  wire logic       wr_sweep,
  input  wire logic       wr_lo,
  input  wire logic       wr_hi,
  input  wire logic       wr_status,
  input  wire logic       enable,
  input  wire logic [7:0] data,
  output logic      [3:0] level
);

  logic [1:0]  duty_r;
  logic        halt_r, const_r, sw_on_r, neg_r, sw_reload_r;
  logic [3:0]  vol_r;
  logic [2:0]  sw_per_r, shift_r, sw_div_r, step_r;
  logic [10:0] period_r, countdown_r;
  logic [7:0]  len_r;
  env_t        env_r;

  logic [10:0] change;
  logic [11:0] target;
  logic        muted;
  logic [7:0]  dmask;

  assign change = period_r >> shift_r;
  always_comb begin
    if (!neg_r) target = {1'b0, period_r} + {1'b0, change};
    else if (CH_ONE) target = (period_r > change) ? {1'b0, period_r - change - 11'd1} : 12'd0;
    else target = {1'b0, period_r - change};
  end
  assign muted = (period_r < 11'd8) || (target > {1'b0, SWEEP_MAX});
  assign dmask = duty_mask(duty_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      duty_r <= '0; halt_r <= 1'b0; const_r <= 1'b0; vol_r <= '0;
      sw_on_r <= 1'b0; sw_per_r <= '0; neg_r <= 1'b0; shift_r <= '0;
      sw_reload_r <= 1'b0; sw_div_r <= '0; step_r <= '0;
      period_r <= '0; countdown_r <= '0; len_r <= '0; env_r <= '0;
    end else begin
      if (apu_clk) begin
        if (countdown_r == 11'd0) begin
          countdown_r <= period_r;
          step_r <= step_r - 3'd1;
        end else begin
          countdown_r <= countdown_r - 11'd1;
        end
      end
      if (quarter) env_r <= env_clock(env_r, vol_r, halt_r);
      if (half) begin
        if (len_r != 8'd0 && !halt_r) len_r <= len_r - 8'd1;
        if (sw_div_r == 3'd0 && sw_on_r && shift_r != 3'd0 && !muted)
          period_r <= target[10:0];
        if (sw_div_r == 3'd0 || sw_reload_r) begin
          sw_div_r <= sw_per_r;
          sw_reload_r <= 1'b0;
        end else begin
          sw_div_r <= sw_div_r - 3'd1;
        end
      end
      if (wr_ctrl) begin
        duty_r <= data[7:6]; halt_r <= data[5]; const_r <= data[4]; vol_r <= data[3:0];
      end
      if (wr_sweep) begin
        sw_on_r <= data[7]; sw_per_r <= data[6:4]; neg_r <= data[3]; shift_r <= data[2:0];
        sw_reload_r <= 1'b1;
      end
      if (wr_lo) period_r <= {period_r[10:8], data};
      if (wr_hi) begin
        if (enable) len_r <= length_lookup(data[7:3]);
        period_r <= {data[2:0], period_r[7:0]};
        step_r <= '0;
        env_r.start <= 1'b1;
      end
      if (wr_status && !enable) len_r <= '0;
    end
  end

  always_comb begin
    if (!dmask[step_r] || muted || len_r == 8'd0) level = '0;
    else level = const_r ? vol_r : env_r.decay;
  end

endmodule
`default_nettype wire
